// ----- rtl/sshash_pkg.sv -----
// sshash_pkg: shared types and byte/word helpers for the signed stream hash.
// No dependencies; used by every module of the signed_stream_hash32 unit.
package sshash_pkg;

    localparam int unsigned HashW  = 32;
    localparam int unsigned LenW   = 31;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned PendN  = 3;
    localparam int unsigned PhaseW = 2;

    // Handoff from the absorb stage to the finishing pipeline.
    typedef struct packed {
        logic [HashW-1:0]              h;
        logic [PhaseW-1:0]             phase;
        logic [PendN-1:0][ByteW-1:0]   bytes;
    } fin_item_t;

    // Absorb state, exposed for checks at the top level.
    typedef struct packed {
        logic              in_message;
        logic [PhaseW-1:0] phase;
    } absorb_status_t;

    function automatic logic [HashW-1:0] sext8(input logic [ByteW-1:0] b);
        return {{(HashW-ByteW){b[ByteW-1]}}, b};
    endfunction

    // Big-endian 16-bit word from two signed bytes, sign-extended to 32 bits.
    function automatic logic [HashW-1:0] word16(input logic [ByteW-1:0] hi,
                                                input logic [ByteW-1:0] lo);
        logic [15:0] w;
        w = {hi, 8'h00} + {{8{lo[ByteW-1]}}, lo};
        return {{16{w[15]}}, w};
    endfunction

    function automatic logic [HashW-1:0] asr(input logic [HashW-1:0] x,
                                             input int unsigned n);
        return HashW'($signed(x) >>> n);
    endfunction

endpackage

// ----- rtl/sshash_in_if.sv -----
// sshash_in_if: byte stream channel (valid/ready plus one message byte, its message_length and a last_byte flag).
// Depends on sshash_pkg for field widths.
interface sshash_in_if;
    logic                          valid;
    logic                          ready;
    logic [sshash_pkg::ByteW-1:0]  data_byte;
    logic [sshash_pkg::LenW-1:0]   message_length;
    logic                          last_byte;

    modport source (output valid, output data_byte, output message_length,
                     output last_byte, input ready);
    modport sink   (input valid, input data_byte, input message_length,
                     input last_byte, output ready);
endinterface

// ----- rtl/sshash_out_if.sv -----
// sshash_out_if: hash result channel (valid/ready plus signed 32-bit hash).
// Depends on sshash_pkg for field widths.
interface sshash_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sshash_pkg::HashW-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

// ----- rtl/sshash_absorb.sv -----
// sshash_absorb: per-byte state update (byte buffering and group mixing round).
// Depends on sshash_pkg and sshash_in_if; feeds sshash_finish.
module sshash_absorb (
    input  logic                       clk,
    input  logic                       rst_n,
    sshash_in_if.sink                  byte_stream,
    input  logic                       fin_ready,
    output logic                       fin_valid,
    output sshash_pkg::fin_item_t      fin,
    output sshash_pkg::absorb_status_t status
);

    logic [sshash_pkg::HashW-1:0]                        running_hash_reg;
    logic [sshash_pkg::HashW-1:0]                        running_hash_next;
    logic [sshash_pkg::PendN-1:0][sshash_pkg::ByteW-1:0] pending_reg;
    logic [sshash_pkg::PendN-1:0][sshash_pkg::ByteW-1:0] pending_next;
    logic [sshash_pkg::PhaseW-1:0]                       phase_reg;
    logic [sshash_pkg::PhaseW-1:0]                       phase_next;
    logic                                                in_message_reg;
    logic                                                in_message_next;

    logic                                accept;
    logic                                empty_msg;
    logic [sshash_pkg::HashW-1:0]        h_start;
    logic [sshash_pkg::PhaseW-1:0]       phase_start;
    logic [sshash_pkg::HashW-1:0]        h_round;
    logic [sshash_pkg::HashW-1:0]        h_mixed;
    logic [sshash_pkg::PhaseW-1:0]       phase_upd;

    function automatic logic [sshash_pkg::HashW-1:0] group_round(
        input logic [sshash_pkg::HashW-1:0]  h_in,
        input logic [sshash_pkg::ByteW-1:0]  b0,
        input logic [sshash_pkg::ByteW-1:0]  b1,
        input logic [sshash_pkg::ByteW-1:0]  b2,
        input logic [sshash_pkg::ByteW-1:0]  b3
    );
        logic [sshash_pkg::HashW-1:0] h;
        logic [sshash_pkg::HashW-1:0] t;
        h = h_in + sshash_pkg::word16(b0, b1);
        t = (sshash_pkg::word16(b2, b3) << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + sshash_pkg::asr(h, 11);
        return h;
    endfunction

    assign byte_stream.ready = fin_ready;
    assign accept    = byte_stream.valid && byte_stream.ready;
    assign empty_msg = !in_message_reg && (byte_stream.message_length == '0);

    // First byte of a message seeds with the length and restarts the group.
    assign h_start     = in_message_reg ? running_hash_reg
                                        : {1'b0, byte_stream.message_length};
    assign phase_start = in_message_reg ? phase_reg : '0;

    assign h_round = group_round(h_start, pending_reg[0], pending_reg[1],
                                 pending_reg[2], byte_stream.data_byte);

    always_comb
    begin
        pending_next = pending_reg;
        if (phase_start == 2'd3)
        begin
            h_mixed   = h_round;
            phase_upd = '0;
        end
        else
        begin
            h_mixed   = h_start;
            phase_upd = phase_start + 2'd1;
            for (int k = 0; k < sshash_pkg::PendN; k++)
            begin
                if (phase_start == sshash_pkg::PhaseW'(k))
                begin
                    pending_next[k] = byte_stream.data_byte;
                end
            end
        end
    end

    always_comb
    begin
        running_hash_next = running_hash_reg;
        phase_next        = phase_reg;
        in_message_next   = in_message_reg;
        if (accept && !empty_msg)
        begin
            running_hash_next = h_mixed;
            if (byte_stream.last_byte)
            begin
                phase_next      = '0;
                in_message_next = 1'b0;
            end
            else
            begin
                phase_next      = phase_upd;
                in_message_next = 1'b1;
            end
        end
    end

    // Empty message hands zero to the finisher; the avalanche keeps it zero.
    assign fin_valid = accept && (empty_msg || byte_stream.last_byte);
    always_comb
    begin
        if (empty_msg)
        begin
            fin.h     = '0;
            fin.phase = '0;
        end
        else
        begin
            fin.h     = h_mixed;
            fin.phase = phase_upd;
        end
        fin.bytes = pending_next;
    end

    assign status.in_message = in_message_reg;
    assign status.phase      = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
            phase_reg        <= '0;
            in_message_reg   <= 1'b0;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
            phase_reg        <= phase_next;
            in_message_reg   <= in_message_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !empty_msg)
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- rtl/sshash_finish.sv -----
// sshash_finish: tail rule and six-step avalanche, pipelined over three stages,
// ending in the result register. Depends on sshash_pkg and sshash_out_if.
module sshash_finish (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fin_valid,
    output logic                  fin_ready,
    input  sshash_pkg::fin_item_t fin,
    sshash_out_if.source          hash_stream
);

    logic                         s1_valid_reg;
    sshash_pkg::fin_item_t        s1_reg;
    logic                         s2_valid_reg;
    logic [sshash_pkg::HashW-1:0] s2_reg;
    logic                         s3_valid_reg;
    logic [sshash_pkg::HashW-1:0] s3_reg;
    logic                         out_valid_reg;
    logic [sshash_pkg::HashW-1:0] out_reg;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic out_ready;

    function automatic logic [sshash_pkg::HashW-1:0] tail_mix(
        input sshash_pkg::fin_item_t f
    );
        logic [sshash_pkg::HashW-1:0] h;
        h = f.h;
        case (f.phase)
            2'd3:
            begin
                h = h + sshash_pkg::word16(f.bytes[0], f.bytes[1]);
                h = h ^ (h << 16);
                h = h ^ (sshash_pkg::sext8(f.bytes[2]) << 18);
                h = h + sshash_pkg::asr(h, 11);
            end
            2'd2:
            begin
                h = h + sshash_pkg::word16(f.bytes[0], f.bytes[1]);
                h = h ^ (h << 11);
                h = h + sshash_pkg::asr(h, 17);
            end
            2'd1:
            begin
                h = h + sshash_pkg::sext8(f.bytes[0]);
                h = h ^ (h << 10);
                h = h + sshash_pkg::asr(h, 1);
            end
            default:
            begin
                h = f.h;
            end
        endcase
        return h;
    endfunction

    function automatic logic [sshash_pkg::HashW-1:0] aval_front(
        input logic [sshash_pkg::HashW-1:0] h_in
    );
        logic [sshash_pkg::HashW-1:0] h;
        h = h_in ^ (h_in << 3);
        h = h + sshash_pkg::asr(h, 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    function automatic logic [sshash_pkg::HashW-1:0] aval_back(
        input logic [sshash_pkg::HashW-1:0] h_in
    );
        logic [sshash_pkg::HashW-1:0] h;
        h = h_in + sshash_pkg::asr(h_in, 17);
        h = h ^ (h << 25);
        h = h + sshash_pkg::asr(h, 6);
        return h;
    endfunction

    // Each stage moves when it is empty or the next one moves.
    assign out_ready = !out_valid_reg || hash_stream.ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign fin_ready = s1_ready;

    assign hash_stream.valid      = out_valid_reg;
    assign hash_stream.hash_value = $signed(out_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= fin_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && fin_valid)
        begin
            s1_reg <= fin;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= tail_mix(s1_reg);
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= aval_front(s2_reg);
        end
        if (out_ready && s3_valid_reg)
        begin
            out_reg <= aval_back(s3_reg);
        end
    end

endmodule

// ----- rtl/signed_stream_hash32_unit.sv -----
// signed_stream_hash32_unit: top level of the streaming signed 32-bit hash.
// Depends on sshash_pkg, sshash_in_if, sshash_out_if, sshash_absorb, sshash_finish.

// Takes one message byte per clock on byte_stream while byte_stream.ready is high,
// a rate set by the running-hash feedback path in the absorb stage (one mixing
// round: two 32-bit adds), and returns one signed 32-bit hash on hash_stream per
// message. The last_byte item (or the lone item of an empty message, whose length
// is 0 and whose hash is 0) passes s1_reg, s2_reg, s3_reg and out_reg before
// hash_stream.valid rises. message_length is sampled only on the first byte of a
// message. The tail rule and the avalanche run in a three-stage pipeline ending in
// the result register, so a held result stalls input only once all stages are full.
module signed_stream_hash32_unit (
    input  logic         clk,
    input  logic         rst_n,
    sshash_in_if.sink    byte_stream,
    sshash_out_if.source hash_stream
);

    logic                       fin_valid;
    logic                       fin_ready;
    sshash_pkg::fin_item_t      fin;
    sshash_pkg::absorb_status_t status;

    sshash_absorb u_absorb (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .fin_ready   (fin_ready),
        .fin_valid   (fin_valid),
        .fin         (fin),
        .status      (status)
    );

    sshash_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .fin_valid   (fin_valid),
        .fin_ready   (fin_ready),
        .fin         (fin),
        .hash_stream (hash_stream)
    );

`ifndef SYNTHESIS
    // Between messages no bytes are buffered.
    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !status.in_message |-> status.phase == '0)
        else $error("byte phase nonzero while idle");

    // Input backpressure only comes from a full pipe behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_stream.ready |-> (hash_stream.valid && !hash_stream.ready))
        else $error("input stalled without a held result");

    // A non-final byte of a non-empty message leaves the block inside a message.
    a_open_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_stream.valid && byte_stream.ready && !byte_stream.last_byte
         && (status.in_message || byte_stream.message_length != '0))
        |=> status.in_message)
        else $error("message closed early");

    // The final byte closes the message.
    a_close_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_stream.valid && byte_stream.ready && byte_stream.last_byte)
        |=> !status.in_message)
        else $error("message not closed on last byte");
`endif

endmodule
